// ===== design/three_point_angle_cosine_top_macros.svh =====
// Assertion macros shared by the angle cosine design.
`ifndef THREE_POINT_ANGLE_COSINE_TOP_MACROS_SVH
`define THREE_POINT_ANGLE_COSINE_TOP_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define TPAC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define TPAC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/tpac_pkg.sv =====
// Shared widths and types of the angle cosine pipeline.
package tpac_pkg;

	localparam int COORD_W   = 32;  // Q15.16 coordinate
	localparam int DIFF_W    = 33;  // exact coordinate difference
	localparam int MAG_W     = 32;  // magnitude of a difference
	localparam int SQ_W      = 64;  // product of two magnitudes
	localparam int SUM_W     = 66;  // sum of three products
	localparam int HALF_W    = 33;  // limb of a sum for the wide products
	localparam int WIDE_W    = 132; // square of a sum, product of two sums
	localparam int QUO_W     = 61;  // quotient of the squared cosine, at most 2^60
	localparam int DIV_STEPS = 61;  // one quotient bit per stage
	localparam int ROOT_W    = 31;  // magnitude of the cosine, at most 2^30
	localparam int COS_W     = 32;  // signed Q1.30 result

	typedef struct packed {
		logic valid;
		logic neg;
		logic degen;
	} flags_t;

endpackage

// ===== design/tpac_vec.sv =====
// Vector differences, squared lengths and dot product (stages 1 to 4).
module tpac_vec (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               in_valid,
	input  logic [tpac_pkg::COORD_W-1:0]       pa [0:2],
	input  logic [tpac_pkg::COORD_W-1:0]       pv [0:2],
	input  logic [tpac_pkg::COORD_W-1:0]       pb [0:2],
	output logic [tpac_pkg::SUM_W-1:0]         dot_s4,
	output logic [tpac_pkg::SUM_W-1:0]         lu_s4,
	output logic [tpac_pkg::SUM_W-1:0]         lv_s4,
	output tpac_pkg::flags_t                   flg_s4
);

	logic [tpac_pkg::MAG_W-1:0] mu_c [0:2];
	logic [tpac_pkg::MAG_W-1:0] mv_c [0:2];
	logic                       su_c [0:2];
	logic                       sv_c [0:2];

	logic [tpac_pkg::MAG_W-1:0] mu_s1 [0:2];
	logic [tpac_pkg::MAG_W-1:0] mv_s1 [0:2];
	logic                       su_s1 [0:2];
	logic                       sv_s1 [0:2];
	logic                       valid_s1;

	logic [tpac_pkg::SQ_W-1:0]  mu2_s2 [0:2];
	logic [tpac_pkg::SQ_W-1:0]  mv2_s2 [0:2];
	logic [tpac_pkg::SQ_W-1:0]  muv_s2 [0:2];
	logic                       sn_s2  [0:2];
	logic                       valid_s2;

	logic [tpac_pkg::SUM_W-1:0] lu_s3;
	logic [tpac_pkg::SUM_W-1:0] lv_s3;
	logic [tpac_pkg::SUM_W-1:0] pos_s3;
	logic [tpac_pkg::SUM_W-1:0] neg_s3;
	logic                       valid_s3;

	logic [tpac_pkg::SUM_W-1:0] pterm [0:2];
	logic [tpac_pkg::SUM_W-1:0] nterm [0:2];

	genvar i;
	generate
		for (i = 0; i < 3; i++) begin : g_axis
			logic [tpac_pkg::DIFF_W-1:0] du;
			logic [tpac_pkg::DIFF_W-1:0] dv;
			logic [tpac_pkg::DIFF_W-1:0] ndu;
			logic [tpac_pkg::DIFF_W-1:0] ndv;
			assign du  = {pa[i][tpac_pkg::COORD_W-1], pa[i]} - {pv[i][tpac_pkg::COORD_W-1], pv[i]};
			assign dv  = {pb[i][tpac_pkg::COORD_W-1], pb[i]} - {pv[i][tpac_pkg::COORD_W-1], pv[i]};
			assign ndu = {tpac_pkg::DIFF_W{1'b0}} - du;
			assign ndv = {tpac_pkg::DIFF_W{1'b0}} - dv;
			// A difference never reaches 2^32 in magnitude, so 32 bits hold it.
			assign su_c[i] = du[tpac_pkg::DIFF_W-1];
			assign sv_c[i] = dv[tpac_pkg::DIFF_W-1];
			assign mu_c[i] = su_c[i] ? ndu[tpac_pkg::MAG_W-1:0] : du[tpac_pkg::MAG_W-1:0];
			assign mv_c[i] = sv_c[i] ? ndv[tpac_pkg::MAG_W-1:0] : dv[tpac_pkg::MAG_W-1:0];
			assign pterm[i] = sn_s2[i] ? '0 : {2'b00, muv_s2[i]};
			assign nterm[i] = sn_s2[i] ? {2'b00, muv_s2[i]} : '0;
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			flg_s4   <= '0;
		end else if (en) begin
			valid_s1     <= in_valid;
			valid_s2     <= valid_s1;
			valid_s3     <= valid_s2;
			flg_s4.valid <= valid_s3;
			flg_s4.neg   <= (neg_s3 > pos_s3);
			flg_s4.degen <= (lu_s3 == '0) || (lv_s3 == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				mu_s1[k]  <= mu_c[k];
				mv_s1[k]  <= mv_c[k];
				su_s1[k]  <= su_c[k];
				sv_s1[k]  <= sv_c[k];
				mu2_s2[k] <= {32'd0, mu_s1[k]} * {32'd0, mu_s1[k]};
				mv2_s2[k] <= {32'd0, mv_s1[k]} * {32'd0, mv_s1[k]};
				muv_s2[k] <= {32'd0, mu_s1[k]} * {32'd0, mv_s1[k]};
				sn_s2[k]  <= su_s1[k] ^ sv_s1[k];
			end
			lu_s3  <= {2'b00, mu2_s2[0]} + {2'b00, mu2_s2[1]} + {2'b00, mu2_s2[2]};
			lv_s3  <= {2'b00, mv2_s2[0]} + {2'b00, mv2_s2[1]} + {2'b00, mv2_s2[2]};
			pos_s3 <= pterm[0] + pterm[1] + pterm[2];
			neg_s3 <= nterm[0] + nterm[1] + nterm[2];
			dot_s4 <= (neg_s3 > pos_s3) ? (neg_s3 - pos_s3) : (pos_s3 - neg_s3);
			lu_s4  <= lu_s3;
			lv_s4  <= lv_s3;
		end
	end

endmodule

// ===== design/tpac_mul.sv =====
// Square of the dot product and product of the squared lengths (stages 5 and 6).
module tpac_mul (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic [tpac_pkg::SUM_W-1:0]     dot,
	input  logic [tpac_pkg::SUM_W-1:0]     lu,
	input  logic [tpac_pkg::SUM_W-1:0]     lv,
	input  tpac_pkg::flags_t               flg_in,
	output logic [tpac_pkg::WIDE_W-1:0]    dot2_s6,
	output logic [tpac_pkg::WIDE_W-1:0]    msq_s6,
	output tpac_pkg::flags_t               flg_s6
);

	localparam int H = tpac_pkg::HALF_W;

	// Each wide product is split into 33-bit limbs, one partial product per multiplier.
	logic [2*H-1:0] dll_s5, dlh_s5, dhh_s5;
	logic [2*H-1:0] all_s5, alh_s5, ahl_s5, ahh_s5;
	tpac_pkg::flags_t flg_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flg_s5 <= '0;
			flg_s6 <= '0;
		end else if (en) begin
			flg_s5 <= flg_in;
			flg_s6 <= flg_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dll_s5 <= {{H{1'b0}}, dot[H-1:0]} * {{H{1'b0}}, dot[H-1:0]};
			dlh_s5 <= {{H{1'b0}}, dot[H-1:0]} * {{H{1'b0}}, dot[2*H-1:H]};
			dhh_s5 <= {{H{1'b0}}, dot[2*H-1:H]} * {{H{1'b0}}, dot[2*H-1:H]};
			all_s5 <= {{H{1'b0}}, lu[H-1:0]} * {{H{1'b0}}, lv[H-1:0]};
			alh_s5 <= {{H{1'b0}}, lu[H-1:0]} * {{H{1'b0}}, lv[2*H-1:H]};
			ahl_s5 <= {{H{1'b0}}, lu[2*H-1:H]} * {{H{1'b0}}, lv[H-1:0]};
			ahh_s5 <= {{H{1'b0}}, lu[2*H-1:H]} * {{H{1'b0}}, lv[2*H-1:H]};
			dot2_s6 <= ({dhh_s5, {(2*H){1'b0}}})
				+ ({{(H-1){1'b0}}, dlh_s5, {(H+1){1'b0}}})
				+ ({{(2*H){1'b0}}, dll_s5});
			msq_s6 <= ({ahh_s5, {(2*H){1'b0}}})
				+ ({{H{1'b0}}, alh_s5, {H{1'b0}}})
				+ ({{H{1'b0}}, ahl_s5, {H{1'b0}}})
				+ ({{(2*H){1'b0}}, all_s5});
		end
	end

endmodule

// ===== design/tpac_div.sv =====
// Restoring divider, one quotient bit per stage: floor(dot^2 * 2^60 / (|u|^2 |v|^2)).
module tpac_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic [tpac_pkg::WIDE_W-1:0]    dot2,
	input  logic [tpac_pkg::WIDE_W-1:0]    msq,
	input  tpac_pkg::flags_t               flg_in,
	output logic [tpac_pkg::QUO_W-1:0]     quo,
	output tpac_pkg::flags_t               flg_out
);

	localparam int W = tpac_pkg::WIDE_W;
	localparam int N = tpac_pkg::DIV_STEPS;
	localparam int Q = tpac_pkg::QUO_W;

	logic [W-1:0]     rem_s [1:N];
	logic [W-1:0]     msq_s [1:N];
	logic [Q-1:0]     quo_s [1:N];
	tpac_pkg::flags_t flg_s [1:N];

	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_step
			logic [W-1:0]     r_in;
			logic [W-1:0]     m_in;
			logic [Q-1:0]     q_in;
			tpac_pkg::flags_t f_in;
			logic             b_in;
			logic [W:0]       t;
			logic [W+1:0]     sub;
			logic             ge;

			if (k == 0) begin : g_first
				// The quotient stays below 2^61, so the top bits of the dividend
				// are already a valid partial remainder.
				assign r_in = {1'b0, dot2[W-1:1]};
				assign b_in = dot2[0];
				assign m_in = msq;
				assign q_in = '0;
				assign f_in = flg_in;
			end else begin : g_next
				assign r_in = rem_s[k];
				assign b_in = 1'b0;
				assign m_in = msq_s[k];
				assign q_in = quo_s[k];
				assign f_in = flg_s[k];
			end

			assign t   = {r_in, b_in};
			assign sub = {1'b0, t} - {2'b00, m_in};
			assign ge  = !sub[W+1];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					flg_s[k+1] <= '0;
				end else if (en) begin
					flg_s[k+1] <= f_in;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= ge ? sub[W-1:0] : t[W-1:0];
					msq_s[k+1] <= m_in;
					quo_s[k+1] <= {q_in[Q-2:0], ge};
				end
			end
		end
	endgenerate

	assign quo     = quo_s[N];
	assign flg_out = flg_s[N];

endmodule

// ===== design/tpac_sqrt.sv =====
// Integer square root, one root bit per stage.
module tpac_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [tpac_pkg::QUO_W-1:0]    quo,
	input  tpac_pkg::flags_t              flg_in,
	output logic [tpac_pkg::ROOT_W-1:0]   root,
	output tpac_pkg::flags_t              flg_out
);

	localparam int R  = tpac_pkg::ROOT_W;
	localparam int Q  = tpac_pkg::QUO_W;
	localparam int TW = 2 * R + 1;

	logic [Q-1:0]     rem_s  [1:R];
	logic [R-1:0]     root_s [1:R];
	tpac_pkg::flags_t flg_s  [1:R];

	genvar k;
	generate
		for (k = 0; k < R; k++) begin : g_step
			localparam int B = R - 1 - k;
			logic [Q-1:0]     r_in;
			logic [R-1:0]     x_in;
			tpac_pkg::flags_t f_in;
			logic [TW-1:0]    trial;
			logic [TW-1:0]    rem_w;
			logic [TW-1:0]    diff;
			logic             ge;

			if (k == 0) begin : g_first
				assign r_in = quo;
				assign x_in = '0;
				assign f_in = flg_in;
			end else begin : g_next
				assign r_in = rem_s[k];
				assign x_in = root_s[k];
				assign f_in = flg_s[k];
			end

			// (x + 2^B)^2 - x^2 = x * 2^(B+1) + 2^(2B)
			assign trial = ({{(TW-R){1'b0}}, x_in} << (B + 1)) + ({{(TW-1){1'b0}}, 1'b1} << (2 * B));
			assign rem_w = {{(TW-Q){1'b0}}, r_in};
			assign ge    = rem_w >= trial;
			assign diff  = rem_w - trial;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					flg_s[k+1] <= '0;
				end else if (en) begin
					flg_s[k+1] <= f_in;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1]  <= ge ? diff[Q-1:0] : r_in;
					root_s[k+1] <= ge ? (x_in | ({{(R-1){1'b0}}, 1'b1} << B)) : x_in;
				end
			end
		end
	endgenerate

	assign root    = root_s[R];
	assign flg_out = flg_s[R];

endmodule

// ===== design/three_point_angle_cosine_top.sv =====
// Top level of the cosine-of-angle pipeline with its output skid stage.
//
// Each input transaction carries three points in signed Q15.16: a first end point,
// the vertex and a second end point. The result transaction gives the cosine of the
// angle at the vertex in signed Q1.30, truncated toward zero, together with a
// degenerate flag that is set, with a cosine of zero, when either vector has zero
// length.
// Both channels use valid and ready. While in_ready is high, a new transaction may be
// accepted in every cycle, and one result leaves per cycle at full rate. A result
// passes through six stages that form the vectors, lengths and wide products, 61
// divider stages that give one quotient bit each, 31 square-root stages that give
// one root bit each, and one output register.
// When the receiver stalls, the pipeline keeps moving until one more result lands
// in the skid register; in_ready then falls until the output register drains.
// Nothing is lost or repeated across a stall.
// Reset clears every valid bit, including those of the output and skid registers;
// in_ready is high as soon as reset is released.
`include "three_point_angle_cosine_top_macros.svh"

module three_point_angle_cosine_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [tpac_pkg::COORD_W-1:0]   first_x,
	input  logic signed [tpac_pkg::COORD_W-1:0]   first_y,
	input  logic signed [tpac_pkg::COORD_W-1:0]   first_z,
	input  logic signed [tpac_pkg::COORD_W-1:0]   vertex_x,
	input  logic signed [tpac_pkg::COORD_W-1:0]   vertex_y,
	input  logic signed [tpac_pkg::COORD_W-1:0]   vertex_z,
	input  logic signed [tpac_pkg::COORD_W-1:0]   second_x,
	input  logic signed [tpac_pkg::COORD_W-1:0]   second_y,
	input  logic signed [tpac_pkg::COORD_W-1:0]   second_z,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [tpac_pkg::COS_W-1:0]     cosine,
	output logic                                  degenerate
);

	logic                                en;
	logic [tpac_pkg::COORD_W-1:0]        pa [0:2];
	logic [tpac_pkg::COORD_W-1:0]        pv [0:2];
	logic [tpac_pkg::COORD_W-1:0]        pb [0:2];
	logic [tpac_pkg::SUM_W-1:0]          dot_s4, lu_s4, lv_s4;
	tpac_pkg::flags_t                    flg_s4, flg_s6, flg_div, flg_sq;
	logic [tpac_pkg::WIDE_W-1:0]         dot2_s6, msq_s6;
	logic [tpac_pkg::QUO_W-1:0]          quo;
	logic [tpac_pkg::ROOT_W-1:0]         root;
	logic [tpac_pkg::COS_W-1:0]          mag;
	logic [tpac_pkg::COS_W-1:0]          res_cos;
	logic                                arrive;
	logic                                out_free;

	logic                                out_valid_q;
	logic [tpac_pkg::COS_W-1:0]          out_cos_q;
	logic                                out_deg_q;
	logic                                skid_valid_q;
	logic [tpac_pkg::COS_W-1:0]          skid_cos_q;
	logic                                skid_deg_q;

	assign pa[0] = first_x;
	assign pa[1] = first_y;
	assign pa[2] = first_z;
	assign pv[0] = vertex_x;
	assign pv[1] = vertex_y;
	assign pv[2] = vertex_z;
	assign pb[0] = second_x;
	assign pb[1] = second_y;
	assign pb[2] = second_z;

	// The pipeline only stops once a result is parked in the skid register.
	assign en       = !skid_valid_q;
	assign in_ready = en;

	tpac_vec u_vec (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.pa       (pa),
		.pv       (pv),
		.pb       (pb),
		.dot_s4   (dot_s4),
		.lu_s4    (lu_s4),
		.lv_s4    (lv_s4),
		.flg_s4   (flg_s4)
	);

	tpac_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.dot     (dot_s4),
		.lu      (lu_s4),
		.lv      (lv_s4),
		.flg_in  (flg_s4),
		.dot2_s6 (dot2_s6),
		.msq_s6  (msq_s6),
		.flg_s6  (flg_s6)
	);

	tpac_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.dot2    (dot2_s6),
		.msq     (msq_s6),
		.flg_in  (flg_s6),
		.quo     (quo),
		.flg_out (flg_div)
	);

	tpac_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.quo     (quo),
		.flg_in  (flg_div),
		.root    (root),
		.flg_out (flg_sq)
	);

	assign mag     = {1'b0, root};
	assign res_cos = flg_sq.degen ? '0 : (flg_sq.neg ? ({tpac_pkg::COS_W{1'b0}} - mag) : mag);
	assign arrive   = en && flg_sq.valid;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || arrive;
			skid_valid_q <= 1'b0;
		end else if (arrive) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_cos_q <= skid_valid_q ? skid_cos_q : res_cos;
			out_deg_q <= skid_valid_q ? skid_deg_q : flg_sq.degen;
		end else if (arrive) begin
			skid_cos_q <= res_cos;
			skid_deg_q <= flg_sq.degen;
		end
	end

	assign out_valid  = out_valid_q;
	assign cosine     = out_cos_q;
	assign degenerate = out_deg_q;

	`TPAC_ASSERT_ALWAYS(a_skid_needs_out, !arst_n || !skid_valid_q || out_valid_q, "skid register full while output register is empty")
	`TPAC_ASSERT(a_skid_only_on_stall, $rose(skid_valid_q) |-> $past(out_valid_q && !out_ready), "skid register filled without a stalled output")
	`TPAC_ASSERT(a_degen_zero, (out_valid_q && out_deg_q) |-> (out_cos_q == '0), "degenerate result with non-zero cosine")
	`TPAC_ASSERT(a_cos_range, out_valid_q |-> ((cosine <= 32'sd1073741824) && (cosine >= -32'sd1073741824)), "cosine magnitude above one")

endmodule

// ===== tb/sv/three_point_angle_cosine_top_tb.sv =====
// Self-checking testbench for the three-point angle cosine pipeline.
`timescale 1ns / 100ps

module three_point_angle_cosine_top_tb;

	typedef logic signed [tpac_pkg::COORD_W-1:0] coord_t;
	typedef logic [255:0] wide_t;

	typedef struct {
		logic signed [tpac_pkg::COS_W-1:0] cosine;
		logic                              degenerate;
	} angle_t;

	logic   clk;
	logic   arst_n;
	logic   in_valid;
	logic   in_ready;
	coord_t first_x, first_y, first_z;
	coord_t vertex_x, vertex_y, vertex_z;
	coord_t second_x, second_y, second_z;
	logic   out_valid;
	logic   out_ready;
	logic signed [tpac_pkg::COS_W-1:0] cosine;
	logic   degenerate;

	angle_t expected_angles[$];
	int     mismatch_count;
	int     stall_left;
	bit     no_idle;

	three_point_angle_cosine_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.first_x(first_x), .first_y(first_y), .first_z(first_z),
		.vertex_x(vertex_x), .vertex_y(vertex_y), .vertex_z(vertex_z),
		.second_x(second_x), .second_y(second_y), .second_z(second_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.cosine(cosine), .degenerate(degenerate)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Exact cosine: the largest q with q^2 * |u|^2 * |v|^2 <= (u.v)^2 * 2^60.
	function automatic angle_t predict_angle(coord_t ax, coord_t ay, coord_t az,
			coord_t vx, coord_t vy, coord_t vz, coord_t bx, coord_t by, coord_t bz);
		longint u[3];
		longint w[3];
		wide_t  mu, mw, len_u, len_w, pos, neg, dot, prod, rhs, cand, q;
		angle_t res;
		u[0] = longint'(ax) - longint'(vx);
		u[1] = longint'(ay) - longint'(vy);
		u[2] = longint'(az) - longint'(vz);
		w[0] = longint'(bx) - longint'(vx);
		w[1] = longint'(by) - longint'(vy);
		w[2] = longint'(bz) - longint'(vz);
		len_u = 0;
		len_w = 0;
		pos = 0;
		neg = 0;
		for (int i = 0; i < 3; i++) begin
			mu = (u[i] < 0) ? -u[i] : u[i];
			mw = (w[i] < 0) ? -w[i] : w[i];
			len_u += mu * mu;
			len_w += mw * mw;
			if ((u[i] < 0) != (w[i] < 0))
				neg += mu * mw;
			else
				pos += mu * mw;
		end
		if (len_u == 0 || len_w == 0) begin
			res.cosine = '0;
			res.degenerate = 1'b1;
			return res;
		end
		dot = (pos >= neg) ? pos - neg : neg - pos;
		prod = len_u * len_w;
		rhs = (dot * dot) << 60;
		q = 0;
		for (int b = 30; b >= 0; b--) begin
			cand = q | (wide_t'(1) << b);
			if (cand * cand * prod <= rhs)
				q = cand;
		end
		res.cosine = (pos >= neg) ? q[tpac_pkg::COS_W-1:0] : -q[tpac_pkg::COS_W-1:0];
		res.degenerate = 1'b0;
		return res;
	endfunction

	task automatic report_mismatch(string what, longint want, longint got);
		$display("mismatch on %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
		mismatch_count++;
	endtask

	// Both channels are sampled at the rising edge; predictions are taken on acceptance.
	always @(posedge clk) begin
		angle_t want;
		if (arst_n && in_valid && in_ready)
			expected_angles.push_back(predict_angle(first_x, first_y, first_z,
				vertex_x, vertex_y, vertex_z, second_x, second_y, second_z));
		if (arst_n && out_valid && out_ready) begin
			if (expected_angles.size() == 0) begin
				report_mismatch("unexpected result transaction", 0, 1);
			end else begin
				want = expected_angles.pop_front();
				if (cosine !== want.cosine)
					report_mismatch("cosine", want.cosine, cosine);
				if (degenerate !== want.degenerate)
					report_mismatch("degenerate", want.degenerate, degenerate);
			end
			stall_left = no_idle ? 0 : $urandom_range(0, 9);
		end
	end

	always @(negedge clk) begin
		out_ready <= (stall_left == 0);
		if (stall_left > 0)
			stall_left--;
	end

	task automatic send_points(coord_t ax, coord_t ay, coord_t az, coord_t vx, coord_t vy,
			coord_t vz, coord_t bx, coord_t by, coord_t bz);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		{first_x, first_y, first_z} = {ax, ay, az};
		{vertex_x, vertex_y, vertex_z} = {vx, vy, vz};
		{second_x, second_y, second_z} = {bx, by, bz};
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	function automatic coord_t small_coord(int span);
		return coord_t'($urandom_range(0, 2 * span) - span);
	endfunction

	task automatic test_directed();
		coord_t mn, mx;
		mn = 32'sh8000_0000;
		mx = 32'sh7fff_ffff;
		// Zero-length vectors, on either side or both.
		send_points(0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_points(5, 6, 7, 5, 6, 7, 1, 2, 3);
		send_points(1, 2, 3, 5, 6, 7, 5, 6, 7);
		send_points(mx, mn, mx, mx, mn, mx, mx, mn, mx);
		// Parallel, antiparallel and orthogonal vectors.
		send_points(32'sh1_0000, 0, 0, 0, 0, 0, 32'sh3_0000, 0, 0);
		send_points(32'sh1_0000, 0, 0, 0, 0, 0, -32'sh3_0000, 0, 0);
		send_points(32'sh1_0000, 0, 0, 0, 0, 0, 0, 32'sh1_0000, 0);
		send_points(0, 0, 1, 0, 0, 0, 1, 1, 0);
		send_points(1, 1, 1, 0, 0, 0, 2, 2, 2);
		// Extreme coordinates give the widest differences.
		send_points(mx, mx, mx, mn, mn, mn, mx, mx, mx);
		send_points(mn, mn, mn, mx, mx, mx, mn, mn, mn);
		send_points(mx, mx, mx, mn, mn, mn, mn, mx, mn);
		send_points(mx, mn, mx, mn, mx, mn, mn, mx, mn);
		send_points(mx, 0, 0, mn, 0, 0, mn, mx, mx);
		send_points(mn, mx, 0, 0, 0, 0, mx, mn, 0);
		send_points(1, 0, 0, 0, 0, 0, mx, 1, 0);
		send_points(1, 1, 0, 0, 0, 0, 1, 0, 0);
		send_points(-1, -1, -1, 0, 0, 0, 1, 1, 1);
		send_points(-1, 0, 0, 0, 0, 0, -1, 0, 1);
	endtask

	task automatic test_random(int count);
		coord_t v[3];
		coord_t a[3];
		coord_t b[3];
		int kind;
		int k;
		for (int n = 0; n < count; n++) begin
			if (n % 300 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			kind = $urandom_range(0, 9);
			for (int i = 0; i < 3; i++) begin
				v[i] = $urandom;
				a[i] = $urandom;
				b[i] = $urandom;
			end
			if (kind >= 4 && kind < 7) begin
				// Nearby points, so that small and near-zero vectors turn up.
				for (int i = 0; i < 3; i++) begin
					a[i] = v[i] + small_coord(4);
					b[i] = v[i] + small_coord(4);
				end
			end else if (kind >= 7 && kind < 9) begin
				// Collinear points exercise cosines of exactly plus and minus one.
				k = $urandom_range(0, 5) - 3;
				if (k >= 0)
					k++;
				for (int i = 0; i < 3; i++) begin
					v[i] = small_coord(1 << 24);
					a[i] = v[i] + small_coord(1 << 20);
					b[i] = v[i] + k * (a[i] - v[i]);
				end
			end else if (kind == 9) begin
				if ($urandom_range(0, 1))
					b = v;
				else
					a = v;
			end
			send_points(a[0], a[1], a[2], v[0], v[1], v[2], b[0], b[1], b[2]);
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		{first_x, first_y, first_z} = '0;
		{vertex_x, vertex_y, vertex_z} = '0;
		{second_x, second_y, second_z} = '0;
		mismatch_count = 0;
		stall_left = 0;
		no_idle = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(1800);
		in_valid = 1'b0;
		while (expected_angles.size() != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#40ms;
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/tpac_pkg.sv
design/tpac_vec.sv
design/tpac_mul.sv
design/tpac_div.sv
design/tpac_sqrt.sv
design/three_point_angle_cosine_top.sv
tb/sv/three_point_angle_cosine_top_tb.sv
